FILE: hdl/decimal_rle_decoder_defines.svh
// Assertion macros shared by the decimal run-length decoder RTL.
`ifndef DECIMAL_RLE_DECODER_DEFINES_SVH
`define DECIMAL_RLE_DECODER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define DRLE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define DRLE_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: hdl/drle_pkg.sv
// Types and constants of the decimal run-length decoder.
package drle_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_MISSING_COUNT  = 3'd1,
        ST_ZERO_COUNT     = 3'd2,
        ST_MISSING_SYMBOL = 3'd3,
        ST_RUN_LONG       = 3'd4,
        ST_TOTAL_LONG     = 3'd5,
        ST_UNPRINTABLE    = 3'd6
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_STRICT    = 2'd0,
        CFG_MAX_RUN   = 2'd1,
        CFG_MAX_TOTAL = 2'd2
    } cfg_index_t;

    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned MAX_RUN_BITS   = 20;
    localparam int unsigned MAX_TOTAL_BITS = 32;

    localparam logic [MAX_RUN_BITS-1:0]   MAX_RUN_RESET   = 20'd10000;
    localparam logic [MAX_TOTAL_BITS-1:0] MAX_TOTAL_RESET = 32'd1000000;

    localparam logic [7:0] DIGIT_LOW  = 8'h30;
    localparam logic [7:0] DIGIT_HIGH = 8'h39;
    localparam logic [7:0] PRINT_LOW  = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;

endpackage

FILE: hdl/decimal_rle_decoder.sv
// Decimal run-length decoder: one request in, at most one run item out per byte.
// Frames arrive one byte per request as groups of decimal digits followed by a
// symbol byte; each symbol (or error) yields one result with the symbol, the run
// length and the frame's running total. The block sustains one byte per cycle
// unless a result waits for m_ready: an input register holds the byte,
// combinational logic (count*10+digit, one total add and the limit compares)
// updates the frame state, and result and valid land in an output register.
// A waiting result still lets one more byte be taken into the input
// register. After an error the rest of the frame is dropped silently up to the
// byte marked frame_end. Configuration writes are taken in any cycle, but are
// only to be issued while the block is idle.
module decimal_rle_decoder #(
    parameter int unsigned COUNT_BITS = 20,
    parameter int unsigned TOTAL_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,

    // Byte input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_in_byte,
    input  logic                   s_frame_end,

    // Run result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_symbol,
    output logic [COUNT_BITS-1:0]  m_run_length,
    output logic [TOTAL_BITS-1:0]  m_total_length,
    output logic [2:0]             m_status,
    output logic                   m_frame_last
);

    `include "decimal_rle_decoder_defines.svh"

    localparam int unsigned PROD_W   = COUNT_BITS + 4;
    localparam int unsigned SUM_W    = ((TOTAL_BITS > COUNT_BITS) ? TOTAL_BITS : COUNT_BITS) + 1;
    localparam int unsigned RCMP_W   = (COUNT_BITS > drle_pkg::MAX_RUN_BITS) ?
                                       COUNT_BITS : drle_pkg::MAX_RUN_BITS;
    localparam int unsigned TCMP_W   = (TOTAL_BITS > drle_pkg::MAX_TOTAL_BITS) ?
                                       TOTAL_BITS : drle_pkg::MAX_TOTAL_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    // Configuration registers
    logic                                strict_reg;
    logic [drle_pkg::MAX_RUN_BITS-1:0]   max_run_reg;
    logic [drle_pkg::MAX_TOTAL_BITS-1:0] max_total_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Frame state
    logic [COUNT_BITS-1:0] count_acc_reg, count_acc_next;
    logic [TOTAL_BITS-1:0] total_acc_reg, total_acc_next;
    logic                  digits_seen_reg, digits_seen_next;
    logic                  count_sat_reg, count_sat_next;
    logic                  dropping_reg, dropping_next;

    // Output register
    logic                  m_valid_reg;
    logic [7:0]            symbol_reg;
    logic [COUNT_BITS-1:0] run_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    drle_pkg::status_t     status_reg;
    logic                  last_reg;

    // Per-byte datapath
    logic                  is_digit;
    logic [3:0]            digit_val;
    logic [PROD_W-1:0]     prod;
    logic                  prod_sat;
    logic [COUNT_BITS-1:0] count_new;
    logic [SUM_W-1:0]      sum;
    logic                  sum_over;
    logic [TOTAL_BITS-1:0] total_new;
    logic                  run_over;
    logic                  total_over;
    logic                  unprintable;
    logic                  emit;
    logic [7:0]            res_symbol;
    logic [COUNT_BITS-1:0] res_run;
    logic [TOTAL_BITS-1:0] res_total;
    drle_pkg::status_t     res_status;
    logic                  out_free;
    logic                  advance;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign advance   = in_valid_reg && (!emit || out_free);
    assign s_ready   = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg    <= 1'b0;
            max_run_reg   <= drle_pkg::MAX_RUN_RESET;
            max_total_reg <= drle_pkg::MAX_TOTAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                drle_pkg::CFG_STRICT:    strict_reg    <= cfg_data[0];
                drle_pkg::CFG_MAX_RUN:   max_run_reg   <= cfg_data[drle_pkg::MAX_RUN_BITS-1:0];
                drle_pkg::CFG_MAX_TOTAL: max_total_reg <= cfg_data[drle_pkg::MAX_TOTAL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Input register: load on accept, empty when the byte moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_frame_end;
        end
    end

    // Digit accumulate: count*10 + digit as shift-add, saturate on overflow
    always_comb begin
        is_digit  = (in_byte_reg >= drle_pkg::DIGIT_LOW) && (in_byte_reg <= drle_pkg::DIGIT_HIGH);
        digit_val = 4'(in_byte_reg - drle_pkg::DIGIT_LOW);
        prod      = (PROD_W'(count_acc_reg) << 3) + (PROD_W'(count_acc_reg) << 1)
                    + PROD_W'(digit_val);
        prod_sat  = |prod[PROD_W-1:COUNT_BITS];
        count_new = prod_sat ? COUNT_MAX : prod[COUNT_BITS-1:0];
    end

    // Run total and limit checks
    always_comb begin
        sum         = SUM_W'(total_acc_reg) + SUM_W'(count_acc_reg);
        sum_over    = sum > SUM_W'(TOTAL_MAX);
        total_new   = sum_over ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
        run_over    = count_sat_reg ||
                      (strict_reg && (RCMP_W'(count_acc_reg) > RCMP_W'(max_run_reg)));
        total_over  = sum_over ||
                      (strict_reg && (TCMP_W'(total_new) > TCMP_W'(max_total_reg)));
        unprintable = strict_reg &&
                      ((in_byte_reg < drle_pkg::PRINT_LOW) || (in_byte_reg > drle_pkg::PRINT_HIGH));
    end

    // Frame state update and result selection
    always_comb begin
        count_acc_next   = count_acc_reg;
        total_acc_next   = total_acc_reg;
        digits_seen_next = digits_seen_reg;
        count_sat_next   = count_sat_reg;
        dropping_next    = dropping_reg;
        emit             = 1'b0;
        res_symbol       = in_byte_reg;
        res_run          = '0;
        res_total        = total_acc_reg;
        res_status       = drle_pkg::ST_OK;

        if (dropping_reg) begin
            // Drop until frame end
            emit = 1'b0;
        end else if (is_digit) begin
            count_acc_next   = count_new;
            count_sat_next   = count_sat_reg || prod_sat;
            digits_seen_next = 1'b1;
            if (in_last_reg) begin
                emit       = 1'b1;
                res_symbol = '0;
                res_run    = count_new;
                res_status = drle_pkg::ST_MISSING_SYMBOL;
            end
        end else if (!digits_seen_reg) begin
            emit       = 1'b1;
            res_status = drle_pkg::ST_MISSING_COUNT;
        end else begin
            emit    = 1'b1;
            res_run = count_acc_reg;
            if (count_acc_reg == '0) begin
                res_status = drle_pkg::ST_ZERO_COUNT;
            end else if (run_over) begin
                res_status = drle_pkg::ST_RUN_LONG;
            end else if (unprintable) begin
                res_status = drle_pkg::ST_UNPRINTABLE;
            end else begin
                res_total      = total_new;
                total_acc_next = total_new;
                if (total_over) begin
                    res_status = drle_pkg::ST_TOTAL_LONG;
                end
            end
            count_acc_next   = '0;
            digits_seen_next = 1'b0;
            count_sat_next   = 1'b0;
        end

        // Clear frame state at frame end or on error
        if (in_last_reg || (emit && (res_status != drle_pkg::ST_OK))) begin
            count_acc_next   = '0;
            total_acc_next   = '0;
            digits_seen_next = 1'b0;
            count_sat_next   = 1'b0;
            dropping_next    = !in_last_reg;
        end
    end

    // Frame state registers: advance with the input byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_acc_reg   <= '0;
            total_acc_reg   <= '0;
            digits_seen_reg <= 1'b0;
            count_sat_reg   <= 1'b0;
            dropping_reg    <= 1'b0;
        end else if (advance) begin
            count_acc_reg   <= count_acc_next;
            total_acc_reg   <= total_acc_next;
            digits_seen_reg <= digits_seen_next;
            count_sat_reg   <= count_sat_next;
            dropping_reg    <= dropping_next;
        end
    end

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            symbol_reg <= res_symbol;
            run_reg    <= res_run;
            total_reg  <= res_total;
            status_reg <= res_status;
            last_reg   <= in_last_reg || (res_status != drle_pkg::ST_OK);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_symbol       = symbol_reg;
    assign m_run_length   = run_reg;
    assign m_total_length = total_reg;
    assign m_status       = status_reg;
    assign m_frame_last   = last_reg;

    // Assertions
    `DRLE_ASSERT_ALWAYS(a_error_ends_frame,
        !m_valid_reg || (status_reg == drle_pkg::ST_OK) || last_reg,
        "error result without frame_last")
    `DRLE_ASSERT_ALWAYS(a_ok_run_nonzero,
        !m_valid_reg || (status_reg != drle_pkg::ST_OK) || (run_reg != '0),
        "ok result with zero run length")
    `DRLE_ASSERT_ALWAYS(a_idle_count_clear,
        digits_seen_reg || ((count_acc_reg == '0) && !count_sat_reg),
        "count state set without digits")
    `DRLE_ASSERT_ALWAYS(a_drop_no_digits,
        !dropping_reg || (!digits_seen_reg && (total_acc_reg == '0)),
        "frame state held while dropping")
    `DRLE_ASSERT_NEXT(a_error_starts_drop,
        advance && emit && (res_status != drle_pkg::ST_OK) && !in_last_reg,
        dropping_reg,
        "error inside frame did not start dropping")

endmodule
